FILE: rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared payload types, result codes and register constants for the
// segment intersection core.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int FIELD_W = 16;
	localparam int OUT_W   = 32;
	localparam int THR_W   = 35;

	localparam logic [THR_W-1:0] THR_RESET = 35'd1;

	// result codes
	localparam logic [1:0] OUTCOME_CROSS    = 2'd0;
	localparam logic [1:0] OUTCOME_PARALLEL = 2'd1;
	localparam logic [1:0] OUTCOME_OUTSIDE  = 2'd2;

	typedef struct packed {
		logic signed [FIELD_W-1:0] first_start_x;
		logic signed [FIELD_W-1:0] first_start_y;
		logic signed [FIELD_W-1:0] first_end_x;
		logic signed [FIELD_W-1:0] first_end_y;
		logic signed [FIELD_W-1:0] second_start_x;
		logic signed [FIELD_W-1:0] second_start_y;
		logic signed [FIELD_W-1:0] second_end_x;
		logic signed [FIELD_W-1:0] second_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic [1:0]              outcome;
		logic signed [OUT_W-1:0] cross_x;
		logic signed [OUT_W-1:0] cross_y;
	} cross_result_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic [1:0] outcome;
		logic       neg_x;
		logic       neg_y;
	} side_ctl_t;

endpackage

FILE: rtl/segment_intersection_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_core
// Crossing test of two 2D segments with the crossing point in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request holding both segments' endpoints.
//   out_valid/out_ready return one result per request, in request order:
//   the outcome code and the crossing point (zero unless the segments cross).
//   cfg_valid/cfg_ready write the parallel threshold; cfg_ready is always
//   high. Write it only while no request is in flight.
// Pipeline: four front stages, two multiply stages, one divider stage per
//   quotient bit, and the rounding/output register.
// Throughput: one request per cycle while the receiver does not stall, set
//   by the one-bit-per-stage divider.
// Reset: all stage valids clear and the threshold returns to 1.
// Receiver stall: a stage holds only while it is full and the one after it
//   cannot advance, so empty stages keep filling and requests keep being
//   taken until the pipeline is full.
// ----------------------------------------------------------------------------
module segment_intersection_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sic_pkg::seg_pair_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sic_pkg::cross_result_t        out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sic_pkg::THR_W-1:0]     cfg_data
);

	localparam int C      = COORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int DW     = 2 * C + 1;
	localparam int PW     = C + DW;
	localparam int NQ     = C + F;
	localparam int SIDE_W = $bits(sic_pkg::side_ctl_t) + 2 * C;
	localparam int OW     = (NQ + 2 > sic_pkg::OUT_W) ? NQ + 2 : sic_pkg::OUT_W;

	logic [sic_pkg::THR_W-1:0] thr_q;

	// front to multiplier
	logic                fr_valid, fr_ready;
	sic_pkg::side_ctl_t  fr_ctl;
	logic signed [C-1:0] fr_sx, fr_sy;
	logic [C-1:0]        fr_mx, fr_my;
	logic [DW-1:0]       fr_num, fr_den;
	logic [SIDE_W-1:0]   fr_side;

	// multiplier to divider
	logic              mu_valid, mu_ready;
	logic [PW-1:0]     mu_px, mu_py;
	logic [DW-1:0]     mu_den;
	logic [SIDE_W-1:0] mu_side;

	// divider to output stage
	logic              dv_valid, dv_ready;
	logic [NQ-1:0]     dv_qx, dv_qy;
	logic [DW-1:0]     dv_rx, dv_ry, dv_den;
	logic [SIDE_W-1:0] dv_side;

	sic_pkg::side_ctl_t  dv_ctl;
	logic signed [C-1:0] dv_sx, dv_sy;
	logic                rnd_x, rnd_y;
	logic [OW-1:0]       off_x, off_y, base_x, base_y, val_x, val_y;
	sic_pkg::cross_result_t res_c;

	logic                   out_vld_q;
	sic_pkg::cross_result_t out_data_q;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sic_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	sic_front #(
		.COORD_BITS (C)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.threshold (thr_q),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.ctl       (fr_ctl),
		.start_x   (fr_sx),
		.start_y   (fr_sy),
		.mag_x     (fr_mx),
		.mag_y     (fr_my),
		.num       (fr_num),
		.den       (fr_den)
	);

	assign fr_side = {fr_ctl, fr_sx, fr_sy};

	sic_mul #(
		.COORD_BITS (C),
		.SIDE_W     (SIDE_W)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.mag_x     (fr_mx),
		.mag_y     (fr_my),
		.num       (fr_num),
		.den_in    (fr_den),
		.side_in   (fr_side),
		.out_valid (mu_valid),
		.out_ready (mu_ready),
		.prod_x    (mu_px),
		.prod_y    (mu_py),
		.den_out   (mu_den),
		.side_out  (mu_side)
	);

	sic_div #(
		.COORD_BITS (C),
		.FRAC_BITS  (F),
		.SIDE_W     (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mu_valid),
		.in_ready  (mu_ready),
		.prod_x    (mu_px),
		.prod_y    (mu_py),
		.den_in    (mu_den),
		.side_in   (mu_side),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.quo_x     (dv_qx),
		.quo_y     (dv_qy),
		.rem_x     (dv_rx),
		.rem_y     (dv_ry),
		.den_out   (dv_den),
		.side_out  (dv_side)
	);

	assign {dv_ctl, dv_sx, dv_sy} = dv_side;

	// round to nearest and add to the start point
	always_comb begin
		rnd_x  = {dv_rx, 1'b0} >= {1'b0, dv_den};
		rnd_y  = {dv_ry, 1'b0} >= {1'b0, dv_den};
		off_x  = OW'(dv_qx) + OW'(rnd_x);
		off_y  = OW'(dv_qy) + OW'(rnd_y);
		base_x = {{(OW-C){dv_sx[C-1]}}, dv_sx} << F;
		base_y = {{(OW-C){dv_sy[C-1]}}, dv_sy} << F;
		val_x  = dv_ctl.neg_x ? base_x - off_x : base_x + off_x;
		val_y  = dv_ctl.neg_y ? base_y - off_y : base_y + off_y;
		res_c.outcome = dv_ctl.outcome;
		if (dv_ctl.outcome == sic_pkg::OUTCOME_CROSS) begin
			res_c.cross_x = val_x[sic_pkg::OUT_W-1:0];
			res_c.cross_y = val_y[sic_pkg::OUT_W-1:0];
		end else begin
			res_c.cross_x = '0;
			res_c.cross_y = '0;
		end
	end

	// output register
	assign dv_ready = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dv_ready) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready) begin
			out_data_q <= res_c;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// Four stages: coordinate differences, cross products, numerators and
// denominator, then sign normalization and classification.
// ----------------------------------------------------------------------------
module sic_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sic_pkg::seg_pair_t                 in_data,
	input  logic [sic_pkg::THR_W-1:0]          threshold,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sic_pkg::side_ctl_t                 ctl,
	output logic signed [COORD_BITS-1:0]       start_x,
	output logic signed [COORD_BITS-1:0]       start_y,
	output logic [COORD_BITS-1:0]              mag_x,
	output logic [COORD_BITS-1:0]              mag_y,
	output logic [2*COORD_BITS:0]              num,
	output logic [2*COORD_BITS:0]              den
);

	localparam int C   = COORD_BITS;
	localparam int DF  = C + 1;
	localparam int PRW = 2 * C + 2;
	localparam int DW  = 2 * C + 1;
	localparam int CW  = (DW > sic_pkg::THR_W) ? DW : sic_pkg::THR_W;

	function automatic logic signed [C-1:0] coord(input logic signed [sic_pkg::FIELD_W-1:0] v);
		logic signed [sic_pkg::FIELD_W+C-1:0] w;
		w = {{C{v[sic_pkg::FIELD_W-1]}}, v};
		return w[C-1:0];
	endfunction

	function automatic logic signed [DF-1:0] diff(input logic signed [C-1:0] p,
			input logic signed [C-1:0] q);
		logic signed [DF-1:0] pe;
		logic signed [DF-1:0] qe;
		pe = {p[C-1], p};
		qe = {q[C-1], q};
		return pe - qe;
	endfunction

	logic rdy1, rdy2, rdy3, rdy4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

	logic signed [DF-1:0] dx21_s1, dy21_s1, dx43_s1, dy43_s1, dx13_s1, dy13_s1;
	logic signed [C-1:0]  x1_s1, y1_s1;

	logic signed [PRW-1:0] pa1_s2, pa2_s2, pb1_s2, pb2_s2, pd1_s2, pd2_s2;
	logic signed [DF-1:0]  dx21_s2, dy21_s2;
	logic signed [C-1:0]   x1_s2, y1_s2;

	logic signed [PRW-1:0] a_s3, b_s3, d_s3;
	logic signed [DF-1:0]  dx21_s3, dy21_s3;
	logic signed [C-1:0]   x1_s3, y1_s3;

	logic signed [PRW-1:0] an, bn, dn;
	logic [DW-1:0]         dmag;
	logic signed [DF-1:0]  absx, absy;
	sic_pkg::side_ctl_t    ctl_c;

	sic_pkg::side_ctl_t    ctl_s4;
	logic signed [C-1:0]   x1_s4, y1_s4;
	logic [C-1:0]          magx_s4, magy_s4;
	logic [DW-1:0]         num_s4, den_s4;

	// stall chain
	assign rdy4     = !vld_s4 || out_ready;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// coordinate extraction
	assign x1 = coord(in_data.first_start_x);
	assign y1 = coord(in_data.first_start_y);
	assign x2 = coord(in_data.first_end_x);
	assign y2 = coord(in_data.first_end_y);
	assign x3 = coord(in_data.second_start_x);
	assign y3 = coord(in_data.second_start_y);
	assign x4 = coord(in_data.second_end_x);
	assign y4 = coord(in_data.second_end_y);

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx21_s1 <= diff(x2, x1);
			dy21_s1 <= diff(y2, y1);
			dx43_s1 <= diff(x4, x3);
			dy43_s1 <= diff(y4, y3);
			dx13_s1 <= diff(x1, x3);
			dy13_s1 <= diff(y1, y3);
			x1_s1   <= x1;
			y1_s1   <= y1;
		end
	end

	// stage 2: cross products
	always_ff @(posedge clk) begin
		if (rdy2) begin
			pa1_s2  <= dx43_s1 * dy13_s1;
			pa2_s2  <= dy43_s1 * dx13_s1;
			pb1_s2  <= dx21_s1 * dy13_s1;
			pb2_s2  <= dy21_s1 * dx13_s1;
			pd1_s2  <= dy43_s1 * dx21_s1;
			pd2_s2  <= dx43_s1 * dy21_s1;
			dx21_s2 <= dx21_s1;
			dy21_s2 <= dy21_s1;
			x1_s2   <= x1_s1;
			y1_s2   <= y1_s1;
		end
	end

	// stage 3: numerators and denominator
	always_ff @(posedge clk) begin
		if (rdy3) begin
			a_s3    <= pa1_s2 - pa2_s2;
			b_s3    <= pb1_s2 - pb2_s2;
			d_s3    <= pd1_s2 - pd2_s2;
			dx21_s3 <= dx21_s2;
			dy21_s3 <= dy21_s2;
			x1_s3   <= x1_s2;
			y1_s3   <= y1_s2;
		end
	end

	// sign normalization and classification
	always_comb begin
		an   = d_s3[PRW-1] ? -a_s3 : a_s3;
		bn   = d_s3[PRW-1] ? -b_s3 : b_s3;
		dn   = d_s3[PRW-1] ? -d_s3 : d_s3;
		dmag = dn[DW-1:0];
		absx = dx21_s3[DF-1] ? -dx21_s3 : dx21_s3;
		absy = dy21_s3[DF-1] ? -dy21_s3 : dy21_s3;
		ctl_c.neg_x = dx21_s3[DF-1];
		ctl_c.neg_y = dy21_s3[DF-1];
		if (dmag == '0 || CW'(dmag) < CW'(threshold)) begin
			ctl_c.outcome = sic_pkg::OUTCOME_PARALLEL;
		end else if (an[PRW-1] || bn[PRW-1] || an > dn || bn > dn) begin
			ctl_c.outcome = sic_pkg::OUTCOME_OUTSIDE;
		end else begin
			ctl_c.outcome = sic_pkg::OUTCOME_CROSS;
		end
	end

	// stage 4
	always_ff @(posedge clk) begin
		if (rdy4) begin
			ctl_s4  <= ctl_c;
			num_s4  <= an[DW-1:0];
			den_s4  <= dmag;
			magx_s4 <= absx[C-1:0];
			magy_s4 <= absy[C-1:0];
			x1_s4   <= x1_s3;
			y1_s4   <= y1_s3;
		end
	end

	assign out_valid = vld_s4;
	assign ctl       = ctl_s4;
	assign start_x   = x1_s4;
	assign start_y   = y1_s4;
	assign mag_x     = magx_s4;
	assign mag_y     = magy_s4;
	assign num       = num_s4;
	assign den       = den_s4;

endmodule

FILE: rtl/sic_mul.sv
// ----------------------------------------------------------------------------
// sic_mul
// Two-stage scaling multiply: segment extent times numerator, split into
// half-width partial products that are summed in the second stage.
// ----------------------------------------------------------------------------
module sic_mul #(
	parameter int COORD_BITS = 16,
	parameter int SIDE_W     = 36
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             mag_x,
	input  logic [COORD_BITS-1:0]             mag_y,
	input  logic [2*COORD_BITS:0]             num,
	input  logic [2*COORD_BITS:0]             den_in,
	input  logic [SIDE_W-1:0]                 side_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3*COORD_BITS:0]             prod_x,
	output logic [3*COORD_BITS:0]             prod_y,
	output logic [2*COORD_BITS:0]             den_out,
	output logic [SIDE_W-1:0]                 side_out
);

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;
	localparam int PW = C + DW;
	localparam int H  = (DW + 1) / 2;
	localparam int HI = DW - H;

	logic rdy1, rdy2;
	logic vld_s1, vld_s2;

	logic [C+H-1:0]    pxl_s1, pyl_s1;
	logic [C+HI-1:0]   pxh_s1, pyh_s1;
	logic [DW-1:0]     den_s1, den_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic [PW-1:0]     px_s2, py_s2;

	assign rdy2     = !vld_s2 || out_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
		end
	end

	// partial products
	always_ff @(posedge clk) begin
		if (rdy1) begin
			pxl_s1  <= mag_x * num[H-1:0];
			pxh_s1  <= mag_x * num[DW-1:H];
			pyl_s1  <= mag_y * num[H-1:0];
			pyh_s1  <= mag_y * num[DW-1:H];
			den_s1  <= den_in;
			side_s1 <= side_in;
		end
	end

	// partial product sum
	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2   <= PW'(pxl_s1) + (PW'(pxh_s1) << H);
			py_s2   <= PW'(pyl_s1) + (PW'(pyh_s1) << H);
			den_s2  <= den_s1;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign prod_x    = px_s2;
	assign prod_y    = py_s2;
	assign den_out   = den_s2;
	assign side_out  = side_s2;

endmodule

FILE: rtl/sic_div.sv
// ----------------------------------------------------------------------------
// sic_div
// Pipelined restoring divider, one quotient bit per stage, dividing both
// scaled products by the shared denominator. The dividend is the product
// followed by FRAC_BITS zero bits.
// ----------------------------------------------------------------------------
module sic_div #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int SIDE_W     = 36
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [3*COORD_BITS:0]                 prod_x,
	input  logic [3*COORD_BITS:0]                 prod_y,
	input  logic [2*COORD_BITS:0]                 den_in,
	input  logic [SIDE_W-1:0]                     side_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [COORD_BITS+FRAC_BITS-1:0]       quo_x,
	output logic [COORD_BITS+FRAC_BITS-1:0]       quo_y,
	output logic [2*COORD_BITS:0]                 rem_x,
	output logic [2*COORD_BITS:0]                 rem_y,
	output logic [2*COORD_BITS:0]                 den_out,
	output logic [SIDE_W-1:0]                     side_out
);

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 1;
	localparam int PW = C + DW;
	localparam int NQ = C + FRAC_BITS;

	logic [NQ:0]       rdy;
	logic [NQ-1:0]     vld_s;
	logic [DW-1:0]     rx_s   [NQ];
	logic [DW-1:0]     ry_s   [NQ];
	logic [NQ-1:0]     qx_s   [NQ];
	logic [NQ-1:0]     qy_s   [NQ];
	logic [C-1:0]      lx_s   [NQ];
	logic [C-1:0]      ly_s   [NQ];
	logic [DW-1:0]     den_s  [NQ];
	logic [SIDE_W-1:0] side_s [NQ];

	assign rdy[NQ]  = out_ready;
	assign in_ready = rdy[0];

	for (genvar i = 0; i < NQ; i++) begin : g_stage
		logic              vld_i;
		logic [DW-1:0]     rx_i, ry_i, den_i;
		logic [NQ-1:0]     qx_i, qy_i;
		logic [C-1:0]      lx_i, ly_i;
		logic [SIDE_W-1:0] side_i;
		logic [DW:0]       tx, ty;
		logic              gex, gey;

		if (i == 0) begin : g_head
			assign vld_i  = in_valid;
			assign rx_i   = prod_x[PW-1:C];
			assign ry_i   = prod_y[PW-1:C];
			assign lx_i   = prod_x[C-1:0];
			assign ly_i   = prod_y[C-1:0];
			assign qx_i   = '0;
			assign qy_i   = '0;
			assign den_i  = den_in;
			assign side_i = side_in;
		end else begin : g_body
			assign vld_i  = vld_s[i-1];
			assign rx_i   = rx_s[i-1];
			assign ry_i   = ry_s[i-1];
			assign lx_i   = lx_s[i-1];
			assign ly_i   = ly_s[i-1];
			assign qx_i   = qx_s[i-1];
			assign qy_i   = qy_s[i-1];
			assign den_i  = den_s[i-1];
			assign side_i = side_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		// trial subtract for one quotient bit
		assign tx  = {rx_i, lx_i[C-1]};
		assign ty  = {ry_i, ly_i[C-1]};
		assign gex = tx >= {1'b0, den_i};
		assign gey = ty >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				rx_s[i]   <= gex ? DW'(tx - {1'b0, den_i}) : DW'(tx);
				ry_s[i]   <= gey ? DW'(ty - {1'b0, den_i}) : DW'(ty);
				qx_s[i]   <= {qx_i[NQ-2:0], gex};
				qy_s[i]   <= {qy_i[NQ-2:0], gey};
				lx_s[i]   <= lx_i << 1;
				ly_s[i]   <= ly_i << 1;
				den_s[i]  <= den_i;
				side_s[i] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[NQ-1];
	assign quo_x     = qx_s[NQ-1];
	assign quo_y     = qy_s[NQ-1];
	assign rem_x     = rx_s[NQ-1];
	assign rem_y     = ry_s[NQ-1];
	assign den_out   = den_s[NQ-1];
	assign side_out  = side_s[NQ-1];

endmodule

FILE: tb/sv/segment_intersection_core_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_core_tb
// Self-checking bench for the segment intersection core: drives segment pairs
// with random gaps, predicts outcome and crossing point with exact integer
// math, and compares every result in order, across several thresholds.
// ----------------------------------------------------------------------------
module segment_intersection_core_tb;

	localparam int LATENCY = 39;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	sic_pkg::seg_pair_t     in_data;
	logic                   out_valid;
	logic                   out_ready;
	sic_pkg::cross_result_t out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [sic_pkg::THR_W-1:0] cfg_data;

	logic [sic_pkg::THR_W-1:0] threshold;
	sic_pkg::cross_result_t    expected_q[$];
	int                        mismatches = 0;
	bit                        hold_off;
	bit                        no_gaps;

	segment_intersection_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rounded offset magnitude: round(mag * num * 2^16 / den), ties away from zero
	function automatic longint unsigned scaled_offset(longint unsigned mag,
		longint unsigned num, longint unsigned den);
		logic [127:0] prod;
		logic [127:0] q;
		logic [127:0] r;
		prod = (128'(mag) * 128'(num)) << 16;
		q = prod / den;
		r = prod % den;
		if (2 * r >= den)
			q = q + 1;
		return longint'(q[63:0]);
	endfunction

	function automatic logic [31:0] crossing_coord(longint p0, longint p1,
		longint unsigned num, longint unsigned den);
		longint          delta;
		longint unsigned off;
		longint unsigned base;
		delta = p1 - p0;
		off = scaled_offset(delta < 0 ? -delta : delta, num, den);
		base = p0 * 65536;
		return delta < 0 ? 32'(base - off) : 32'(base + off);
	endfunction

	function automatic sic_pkg::cross_result_t predict_crossing(sic_pkg::seg_pair_t s);
		sic_pkg::cross_result_t res;
		longint x1, y1, x2, y2, x3, y3, x4, y4, a, b, d;
		x1 = s.first_start_x;  y1 = s.first_start_y;
		x2 = s.first_end_x;    y2 = s.first_end_y;
		x3 = s.second_start_x; y3 = s.second_start_y;
		x4 = s.second_end_x;   y4 = s.second_end_y;
		a = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
		b = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
		d = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
		res = '0;
		if (d < 0) begin
			a = -a;
			b = -b;
			d = -d;
		end
		if (d == 0 || longint'(d) < longint'({29'd0, threshold}))
			res.outcome = sic_pkg::OUTCOME_PARALLEL;
		else if (a < 0 || a > d || b < 0 || b > d)
			res.outcome = sic_pkg::OUTCOME_OUTSIDE;
		else begin
			res.outcome = sic_pkg::OUTCOME_CROSS;
			res.cross_x = crossing_coord(x1, x2, a, d);
			res.cross_y = crossing_coord(y1, y2, a, d);
		end
		return res;
	endfunction

	// send one request, after a random gap unless no_gaps is set
	task automatic send_pair(sic_pkg::seg_pair_t s);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		expected_q.push_back(predict_crossing(s));
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_threshold(logic [sic_pkg::THR_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		threshold = v;
	endtask

	function automatic sic_pkg::seg_pair_t random_pair();
		sic_pkg::seg_pair_t s;
		int                 sel;
		int                 span;
		sel = $urandom_range(0, 3);
		span = sel == 0 ? 32767 : (sel == 1 ? 255 : (sel == 2 ? 15 : 2));
		s.first_start_x  = 16'($urandom_range(0, 2 * span) - span);
		s.first_start_y  = 16'($urandom_range(0, 2 * span) - span);
		s.first_end_x    = 16'($urandom_range(0, 2 * span) - span);
		s.first_end_y    = 16'($urandom_range(0, 2 * span) - span);
		s.second_start_x = 16'($urandom_range(0, 2 * span) - span);
		s.second_start_y = 16'($urandom_range(0, 2 * span) - span);
		s.second_end_x   = 16'($urandom_range(0, 2 * span) - span);
		s.second_end_y   = 16'($urandom_range(0, 2 * span) - span);
		if (sel == 0 && $urandom_range(0, 3) == 0)
			s = sic_pkg::seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
		// make the second segment straddle the first for a likely crossing
		if ($urandom_range(0, 1) == 1) begin
			s.second_start_x = 16'((int'(s.first_start_x) + int'(s.first_end_x)) / 2
				- $urandom_range(0, 8));
			s.second_end_x   = 16'(int'(s.second_start_x) + $urandom_range(1, 16));
		end
		return s;
	endfunction

	function automatic sic_pkg::seg_pair_t make_pair(int x1, int y1, int x2, int y2,
		int x3, int y3, int x4, int y4);
		sic_pkg::seg_pair_t s;
		s.first_start_x = 16'(x1);  s.first_start_y = 16'(y1);
		s.first_end_x = 16'(x2);    s.first_end_y = 16'(y2);
		s.second_start_x = 16'(x3); s.second_start_y = 16'(y3);
		s.second_end_x = 16'(x4);   s.second_end_y = 16'(y4);
		return s;
	endfunction

	// result checker
	always @(posedge clk) begin
		sic_pkg::cross_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				exp_res = expected_q.pop_front();
				if (out_data.outcome !== exp_res.outcome
						|| out_data.cross_x !== exp_res.cross_x
						|| out_data.cross_y !== exp_res.cross_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %h %h, got %0d %h %h",
							exp_res.outcome, exp_res.cross_x, exp_res.cross_y,
							out_data.outcome, out_data.cross_x, out_data.cross_y);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 7) == 0)
				wait_cycles = 0;
			out_ready <= wait_cycles == 0;
			repeat (wait_cycles == 0 ? 1 : wait_cycles) @(posedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic test_directed();
		send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
		send_pair(make_pair(0, 0, 4, 0, 4, -2, 4, 2));
		send_pair(make_pair(0, 0, 4, 0, 0, -2, 0, 2));
		send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
		send_pair(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
		send_pair(make_pair(0, 0, 0, 0, 1, 1, 2, 3));
		send_pair(make_pair(0, 0, 10, 10, 20, 0, 30, -10));
		send_pair(make_pair(0, 0, 3, 0, 1, -1, 2, 1));
		send_pair(make_pair(0, 0, 3, 1, 1, -5, 2, 7));
		send_pair(make_pair(3, 0, 0, 0, 1, -1, 2, 1));
		send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767,
			-32768));
		send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767,
			32767));
		send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 0, -32768, 0));
		send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
		send_pair(make_pair(0, 0, 1, 2, 1, 0, 0, 1));
		send_pair(make_pair(0, 0, 7, 0, 1, -1, 1, 2));
		drop_valid();
	endtask

	task automatic test_random(int count);
		repeat (count) send_pair(random_pair());
		drop_valid();
	endtask

	task automatic test_back_to_back(int count);
		no_gaps = 1'b1;
		repeat (count) send_pair(random_pair());
		drop_valid();
		no_gaps = 1'b0;
	endtask

	task automatic test_receiver_hold();
		hold_off = 1'b1;
		no_gaps = 1'b1;
		repeat (120) send_pair(random_pair());
		drop_valid();
		no_gaps = 1'b0;
	endtask

	task automatic test_thresholds();
		write_threshold(35'd0);
		test_directed();
		test_random(250);
		drain();
		write_threshold(35'h7_FFFF_FFFF);
		test_random(60);
		drain();
		write_threshold(35'd4_000_000);
		test_random(300);
		drain();
		write_threshold(35'd17179869184);
		test_random(40);
		drain();
		write_threshold(35'd2);
		test_directed();
		drain();
		write_threshold(35'($urandom_range(0, 65535)));
		test_random(300);
		drain();
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		threshold = sic_pkg::THR_RESET;
		hold_off = 1'b0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_back_to_back(200);
		test_receiver_hold();
		drain();
		test_thresholds();
		write_threshold(sic_pkg::THR_RESET);
		test_random(150);
		drain();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// timeout
	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
